[rtl/sedv_pkg.sv]
// shared types, constants and command codes for the sinc3 edge count voltage decimator
// no dependencies; imported by every module of the block
`default_nettype none

package sedv_pkg;

  // decimation ratio, a power of two so the gain divide is a shift
  localparam int DECIMATION  = 16;
  localparam int PHASE_W     = $clog2(DECIMATION);
  localparam int FILTER_GAIN = DECIMATION * DECIMATION * DECIMATION;
  localparam int GAIN_SHIFT  = 3 * $clog2(DECIMATION);

  localparam int MID_SCALE_EDGES = 250;
  localparam int EDGE_SPAN       = 200;
  localparam int PER_MILLE       = 1000;

  localparam logic [31:0] OFFSET_BASE = 32'(FILTER_GAIN * MID_SCALE_EDGES);
  localparam logic [31:0] SPAN_DIV    = 32'(EDGE_SPAN);
  localparam logic [31:0] MILLE_DIV   = 32'(PER_MILLE);

  // floor(2^32 / d): quotient estimate is exact or one low
  localparam longint unsigned TWO_POW_32 = 64'd4294967296;
  localparam logic [31:0] SPAN_RECIP  = 32'(TWO_POW_32 / EDGE_SPAN);
  localparam logic [31:0] MILLE_RECIP = 32'(TWO_POW_32 / PER_MILLE);

  // register map
  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_FULL_SCALE = 2'd0;
  localparam logic [1:0] REG_CALIB      = 2'd1;
  localparam logic [1:0] REG_FAULT_LOW  = 2'd2;
  localparam logic [1:0] REG_FAULT_HIGH = 2'd3;

  localparam logic [9:0]  FULL_SCALE_RST = 10'd376;
  localparam logic [10:0] CALIB_RST      = 11'd995;
  localparam logic [15:0] FAULT_LOW_RST  = 16'd32;
  localparam logic [15:0] FAULT_HIGH_RST = 16'd500;

  // datapath operations
  typedef logic [3:0] op_t;
  localparam op_t OP_NONE     = 4'd0;
  localparam op_t OP_COMB0    = 4'd1;
  localparam op_t OP_COMB1    = 4'd2;
  localparam op_t OP_COMB2    = 4'd3;
  localparam op_t OP_OFFSET   = 4'd4;
  localparam op_t OP_RECIP_A  = 4'd5;
  localparam op_t OP_BACK_A   = 4'd6;
  localparam op_t OP_FIX_A    = 4'd7;
  localparam op_t OP_GAIN     = 4'd8;
  localparam op_t OP_CALIB    = 4'd9;
  localparam op_t OP_RECIP_B  = 4'd10;
  localparam op_t OP_BACK_B   = 4'd11;
  localparam op_t OP_FIX_B    = 4'd12;

  typedef struct packed {
    logic [9:0]  full_scale_volts;
    logic [10:0] calib_per_mille;
    logic [15:0] fault_low;
    logic [15:0] fault_high;
  } cfg_t;

  typedef struct packed {
    logic load;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic        range_fault;
    logic        fresh;
    logic [15:0] volt_tenths;
  } res_t;

endpackage

`default_nettype wire

[rtl/sedv_regs.sv]
// apb configuration registers for the decimator
// depends on sedv_pkg for the register map and reset values
`default_nettype none

module sedv_regs
  import sedv_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.full_scale_volts <= FULL_SCALE_RST;
      cfg.calib_per_mille  <= CALIB_RST;
      cfg.fault_low        <= FAULT_LOW_RST;
      cfg.fault_high       <= FAULT_HIGH_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FULL_SCALE: cfg.full_scale_volts <= pwdata[9:0];
        REG_CALIB:      cfg.calib_per_mille  <= pwdata[10:0];
        REG_FAULT_LOW:  cfg.fault_low        <= pwdata[15:0];
        REG_FAULT_HIGH: cfg.fault_high       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FULL_SCALE: prdata = {22'd0, cfg.full_scale_volts};
      REG_CALIB:      prdata = {21'd0, cfg.calib_per_mille};
      REG_FAULT_LOW:  prdata = {16'd0, cfg.fault_low};
      REG_FAULT_HIGH: prdata = {16'd0, cfg.fault_high};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/sedv_datapath.sv]
// cic integrators, comb delays and the shared-multiplier scaling datapath
// depends on sedv_pkg; driven by commands from sedv_ctrl
`default_nettype none

module sedv_datapath
  import sedv_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  input  wire cfg_t        cfg,
  input  wire logic [15:0] edge_count,
  output res_t             res
);

  logic [31:0] integ0, integ1, integ2;
  logic [31:0] comb0, comb1, comb2;
  logic [15:0] held;

  // scaling work registers
  logic [31:0] x;
  logic [31:0] q;
  logic [31:0] p;
  logic        fault_q;

  logic        fault_now;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [31:0] q_ten;
  logic [31:0] div_const;
  logic [31:0] rem;
  logic        q_inc;
  logic [31:0] q_fixed;
  logic        final_step;

  assign fault_now  = (edge_count < cfg.fault_low) || (edge_count > cfg.fault_high);
  assign q_ten      = (q << 3) + (q << 1);
  assign final_step = (cmd.op == OP_FIX_B);
  assign div_const  = final_step ? MILLE_DIV : SPAN_DIV;
  assign rem        = x - p;
  assign q_inc      = (rem >= div_const);
  assign q_fixed    = q + {31'd0, q_inc};

  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (cmd.op)
      OP_RECIP_A: begin mul_a = x; mul_b = SPAN_RECIP;  end
      OP_RECIP_B: begin mul_a = x; mul_b = MILLE_RECIP; end
      OP_BACK_A:  begin mul_a = q; mul_b = SPAN_DIV;    end
      OP_BACK_B:  begin mul_a = q; mul_b = MILLE_DIV;   end
      OP_GAIN: begin
        mul_a = q_ten;
        mul_b = {22'd0, cfg.full_scale_volts};
      end
      OP_CALIB: begin
        mul_a = x >> GAIN_SHIFT;
        mul_b = {21'd0, cfg.calib_per_mille};
      end
      default: ;
    endcase
  end

  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  // filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      integ0 <= 32'd0;
      integ1 <= 32'd0;
      integ2 <= 32'd0;
      comb0  <= 32'd0;
      comb1  <= 32'd0;
      comb2  <= 32'd0;
      held   <= 16'd0;
    end else begin
      if (cmd.load) begin
        integ2 <= integ2 + integ1;
        integ1 <= integ1 + integ0;
        integ0 <= integ0 + {16'd0, edge_count};
      end
      case (cmd.op)
        OP_COMB0: comb0 <= integ2;
        OP_COMB1: comb1 <= x;
        OP_COMB2: comb2 <= x;
        OP_FIX_B: held  <= q_fixed[15:0];
        default: ;
      endcase
    end
  end

  // scaling work registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fault_q <= fault_now;
    end
    case (cmd.op)
      OP_COMB0:   x <= integ2 - comb0;
      OP_COMB1:   x <= x - comb1;
      OP_COMB2:   x <= x - comb2;
      OP_OFFSET:  x <= OFFSET_BASE - x;
      OP_RECIP_A: q <= mul_p[63:32];
      OP_RECIP_B: q <= mul_p[63:32];
      OP_BACK_A:  p <= mul_p[31:0];
      OP_BACK_B:  p <= mul_p[31:0];
      OP_FIX_A:   q <= q_fixed;
      OP_GAIN:    x <= mul_p[31:0];
      OP_CALIB:   x <= mul_p[31:0];
      default: ;
    endcase
  end

  // a load without a decimation step returns the held voltage right away
  assign res = {final_step ? fault_q : fault_now,
                final_step,
                final_step ? q_fixed[15:0] : held};

endmodule

`default_nettype wire

[rtl/sedv_ctrl.sv]
// controller: input handshake, decimation phase and the scaling sequence
// depends on sedv_pkg; commands sedv_datapath and pushes into sedv_outq
`default_nettype none

module sedv_ctrl
  import sedv_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic q_full,
  output cmd_t      cmd,
  output logic      push
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_COMB0   = 4'd1;
  localparam logic [3:0] S_COMB1   = 4'd2;
  localparam logic [3:0] S_COMB2   = 4'd3;
  localparam logic [3:0] S_OFFSET  = 4'd4;
  localparam logic [3:0] S_RECIP_A = 4'd5;
  localparam logic [3:0] S_BACK_A  = 4'd6;
  localparam logic [3:0] S_FIX_A   = 4'd7;
  localparam logic [3:0] S_GAIN    = 4'd8;
  localparam logic [3:0] S_CALIB   = 4'd9;
  localparam logic [3:0] S_RECIP_B = 4'd10;
  localparam logic [3:0] S_BACK_B  = 4'd11;
  localparam logic [3:0] S_FIX_B   = 4'd12;

  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(DECIMATION - 1);

  logic [3:0]         state, state_next;
  logic [PHASE_W-1:0] phase, phase_next;
  logic               accept;
  logic               wrap;

  assign in_ready = (state == S_IDLE) && !q_full;
  assign accept   = in_valid && in_ready;
  assign wrap     = (phase == PHASE_LAST);
  assign push     = (accept && !wrap) || (state == S_FIX_B);

  always_comb begin
    phase_next = phase;
    if (accept) begin
      phase_next = wrap ? '0 : phase + 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    cmd.load   = accept;
    cmd.op     = OP_NONE;
    unique case (state)
      S_IDLE:    if (accept && wrap) state_next = S_COMB0;
      S_COMB0:   begin cmd.op = OP_COMB0;   state_next = S_COMB1;   end
      S_COMB1:   begin cmd.op = OP_COMB1;   state_next = S_COMB2;   end
      S_COMB2:   begin cmd.op = OP_COMB2;   state_next = S_OFFSET;  end
      S_OFFSET:  begin cmd.op = OP_OFFSET;  state_next = S_RECIP_A; end
      S_RECIP_A: begin cmd.op = OP_RECIP_A; state_next = S_BACK_A;  end
      S_BACK_A:  begin cmd.op = OP_BACK_A;  state_next = S_FIX_A;   end
      S_FIX_A:   begin cmd.op = OP_FIX_A;   state_next = S_GAIN;    end
      S_GAIN:    begin cmd.op = OP_GAIN;    state_next = S_CALIB;   end
      S_CALIB:   begin cmd.op = OP_CALIB;   state_next = S_RECIP_B; end
      S_RECIP_B: begin cmd.op = OP_RECIP_B; state_next = S_BACK_B;  end
      S_BACK_B:  begin cmd.op = OP_BACK_B;  state_next = S_FIX_B;   end
      S_FIX_B:   begin cmd.op = OP_FIX_B;   state_next = S_IDLE;    end
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= '0;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

`ifndef SYNTHESIS
  a_wrap_starts_comb: assert property (@(posedge clk) disable iff (rst)
    (accept && wrap) |=> (state == S_COMB0))
    else $error("decimation step did not start the comb sequence");

  a_fix_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIX_B) |=> (state == S_IDLE) && (phase == '0))
    else $error("sequence end did not return to idle at phase zero");

  a_busy_holds_phase: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |=> $stable(phase))
    else $error("phase moved while the scaling sequence ran");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("result pushed into a full output queue");
`endif

endmodule

`default_nettype wire

[rtl/sedv_outq.sv]
// two-entry result queue between the datapath and the output channel
// depends on sedv_pkg for the result struct
`default_nettype none

module sedv_outq
  import sedv_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire res_t push_data,
  output logic      q_full,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      out_data
);

  res_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign out_valid = (count != 2'd0);
  assign q_full    = (count == 2'd2);
  assign pop       = out_valid && out_ready;
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("output queue count overflow");

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    ((count == 2'd0) || (count == 2'd2)) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("waiting transaction dropped or changed");
`endif

endmodule

`default_nettype wire

[rtl/sinc3_edge_count_voltage_decimator_top.sv]
// an item that does not close a decimation period is pushed into the output queue as it is
// accepted; the closing item runs the comb, offset, two divides and two gains first
// throughput is one item per cycle while the output queue is not full, except that the
// closing item holds the input while the shared multiplier runs the scaling sequence
// reset: synchronous rst clears filter state, phase, held voltage and queue, and loads
// register defaults; no clearing pass is needed
`default_nettype none

module sinc3_edge_count_voltage_decimator_top
  import sedv_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [15:0]       edge_count,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   range_fault,
  output logic                   fresh,
  output logic      [15:0]       volt_tenths
);

  cfg_t cfg;
  cmd_t cmd;
  res_t res;
  res_t out_data;
  logic push;
  logic q_full;

  sedv_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sedv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .q_full   (q_full),
    .cmd      (cmd),
    .push     (push)
  );

  sedv_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg        (cfg),
    .edge_count (edge_count),
    .res        (res)
  );

  sedv_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res),
    .q_full    (q_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign range_fault = out_data.range_fault;
  assign fresh       = out_data.fresh;
  assign volt_tenths = out_data.volt_tenths;

endmodule

`default_nettype wire
